// File: hw/rtl/bcdg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcdg_pkg
// Shared constants, register indexes, command codes and sequencer states for
// the bilinear charge deposition grid.
// ----------------------------------------------------------------------------
package bcdg_pkg;

  // Grid geometry
  localparam int GRID_X     = 64;
  localparam int GRID_Y     = 64;
  localparam int GRID_CELLS = GRID_X * GRID_Y;
  localparam int COL_W      = (GRID_X > 2) ? $clog2(GRID_X) : 1;
  localparam int ROW_W      = (GRID_Y > 2) ? $clog2(GRID_Y) : 1;
  localparam int ADDR_W     = $clog2(GRID_CELLS);

  // Data and port widths
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int RD_IDX_W  = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SCALE = 3'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // Unit weight in Q16.16
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_LOCX,
    S_LOCY,
    S_CHARGE,
    S_SCALE,
    S_BHI,
    S_BLO,
    S_BSUM,
    S_CHI,
    S_CLO,
    S_CSUM,
    S_ADD,
    S_RDREQ,
    S_RDCAP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/bilinear_charge_deposition_grid_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_charge_deposition_grid_top
// Cloud-in-cell charge deposition onto a GRID_X by GRID_Y Q16.16 density grid.
//
// Input channel (in_valid / in_stall) carries one command per transaction:
// clear, deposit or read. Every transaction gives exactly one result on the
// output channel (out_valid / out_stall): the read cell value, the
// out-of-mesh flag and the saturation flag.
// Work is done by one shared 33x33 signed multiplier and one single-port grid
// memory under a sequencer; one command is in flight at a time.
// The sequencer returns to idle as the result is registered, so a new
// transaction can be taken while that result is on the output. A deposit
// inside the grid makes nineteen passes through the multiplier and four
// read-modify-writes of the memory.
// Reset: configuration registers take their reset values and the grid is
// zeroed by a sweep over all GRID_CELLS (4096) cells, with in_stall high
// meanwhile; configuration writes are taken at any time.
// A stalled result holds in the output register; the next transaction may be
// accepted and worked on, and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module bilinear_charge_deposition_grid_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [bcdg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bcdg_pkg::DATA_W-1:0]           cfg_data,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [bcdg_pkg::CMD_W-1:0]            in_command,
  input  wire logic signed [bcdg_pkg::DATA_W-1:0]    in_pos_x,
  input  wire logic signed [bcdg_pkg::DATA_W-1:0]    in_pos_y,
  input  wire logic signed [bcdg_pkg::DATA_W-1:0]    in_particle_charge,
  input  wire logic [bcdg_pkg::RD_IDX_W-1:0]         in_read_col,
  input  wire logic [bcdg_pkg::RD_IDX_W-1:0]         in_read_row,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [bcdg_pkg::DATA_W-1:0]         out_cell_value,
  output logic                                       out_out_of_mesh,
  output logic                                       out_saturated
);
  import bcdg_pkg::*;

  localparam logic signed [48:0] SUM_MAX = 49'sd2147483647;
  localparam logic signed [48:0] SUM_MIN = -49'sd2147483648;

  // Configuration registers
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [31:0]        inv_x_r, inv_y_r, scale_r;

  // Sequencer
  state_t state_r, state_nxt;
  logic              init_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [1:0]        node_r;
  logic              in_accept;
  logic              out_free;

  // Datapath registers
  logic signed [32:0] dx_r, dy_r;
  logic signed [31:0] charge_r;
  logic [COL_W-1:0]   ix_r;
  logic [ROW_W-1:0]   iy_r;
  logic [15:0]        fx_r, fy_r;
  logic signed [47:0] a_r;
  logic signed [47:0] val_r;
  logic signed [48:0] acc_r;
  logic signed [65:0] mul_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic               rd_ok_r;
  logic [CMD_W-1:0]   cmd_r;

  // Result staging and output registers
  logic signed [31:0] res_cell_r;
  logic               res_oob_r, res_sat_r;
  logic               out_valid_r;
  logic signed [31:0] out_cell_r;
  logic               out_oob_r, out_sat_r;

  // Shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  // Memory port
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic signed [31:0] mem_wdata;
  logic signed [31:0] mem_rdata_r;
  logic signed [31:0] grid_mem [GRID_CELLS];

  // Combinational helpers
  logic [16:0]        wx, wy;
  logic [ADDR_W-1:0]  node_addr;
  logic               loc_neg;
  logic [31:0]        loc_lim;
  logic               loc_oob;
  logic signed [48:0] cell_sum;
  logic               sum_hi, sum_lo;
  logic signed [31:0] sum_sat;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Bilinear weights for the current node
  assign wx = node_r[0] ? {1'b0, fx_r} : (WEIGHT_ONE - {1'b0, fx_r});
  assign wy = node_r[1] ? {1'b0, fy_r} : (WEIGHT_ONE - {1'b0, fy_r});

  assign node_addr = (ADDR_W'(iy_r) + ADDR_W'(node_r[1])) * ADDR_W'(GRID_X)
                   + ADDR_W'(ix_r) + ADDR_W'(node_r[0]);

  // Axis bounds check on the fresh product: x in LOCY, y in CHARGE
  assign loc_neg = (state_r == S_CHARGE) ? dy_r[32] : dx_r[32];
  assign loc_lim = (state_r == S_CHARGE) ? 32'(GRID_Y - 1) : 32'(GRID_X - 1);
  assign loc_oob = loc_neg ? (mul_r != '0) : (mul_r[63:32] >= loc_lim);

  // Saturating cell update
  assign cell_sum = 49'(mem_rdata_r) + 49'(val_r);
  assign sum_hi   = cell_sum > SUM_MAX;
  assign sum_lo   = cell_sum < SUM_MIN;
  assign sum_sat  = sum_hi ? 32'sh7fffffff :
                    sum_lo ? 32'sh80000000 : cell_sum[31:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      inv_x_r    <= 32'h0001_0000;
      inv_y_r    <= 32'h0001_0000;
      scale_r    <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:     origin_x_r <= cfg_data;
        CFG_ORIGIN_Y:     origin_y_r <= cfg_data;
        CFG_INV_WIDTH_X:  inv_x_r    <= cfg_data;
        CFG_INV_WIDTH_Y:  inv_y_r    <= cfg_data;
        CFG_CHARGE_SCALE: scale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_CLEAR:   state_nxt = S_CLEAR;
            CMD_DEPOSIT: state_nxt = S_LOCX;
            CMD_READ:    state_nxt = S_RDREQ;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(GRID_CELLS - 1)) begin
          state_nxt = init_r ? S_IDLE : S_DONE;
        end
      end
      S_LOCX:   state_nxt = S_LOCY;
      S_LOCY:   state_nxt = S_CHARGE;
      S_CHARGE: state_nxt = (res_oob_r || loc_oob) ? S_DONE : S_SCALE;
      S_SCALE:  state_nxt = S_BHI;
      S_BHI:    state_nxt = S_BLO;
      S_BLO:    state_nxt = S_BSUM;
      S_BSUM:   state_nxt = S_CHI;
      S_CHI:    state_nxt = S_CLO;
      S_CLO:    state_nxt = S_CSUM;
      S_CSUM:   state_nxt = S_ADD;
      S_ADD:    state_nxt = (node_r == 2'd3) ? S_DONE : S_BHI;
      S_RDREQ:  state_nxt = S_RDCAP;
      S_RDCAP:  state_nxt = S_DONE;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, memory port
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = rd_addr_r;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
      end
      S_LOCX: begin
        mul_a = dx_r;
        mul_b = $signed({1'b0, inv_x_r});
      end
      S_LOCY: begin
        mul_a = dy_r;
        mul_b = $signed({1'b0, inv_y_r});
      end
      S_CHARGE: begin
        mul_a = $signed({charge_r[31], charge_r});
        mul_b = $signed({1'b0, scale_r});
      end
      S_BHI: begin
        mul_a = $signed({a_r[47], a_r[47:16]});
        mul_b = $signed({16'b0, wx});
      end
      S_BLO: begin
        mul_a = $signed({17'b0, a_r[15:0]});
        mul_b = $signed({16'b0, wx});
      end
      S_CHI: begin
        mul_a    = $signed({val_r[47], val_r[47:16]});
        mul_b    = $signed({16'b0, wy});
        mem_re   = 1'b1;
        mem_addr = node_addr;
      end
      S_CLO: begin
        mul_a = $signed({17'b0, val_r[15:0]});
        mul_b = $signed({16'b0, wy});
      end
      S_ADD: begin
        mem_we    = 1'b1;
        mem_addr  = node_addr;
        mem_wdata = sum_sat;
      end
      S_RDREQ: begin
        mem_re = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      init_r    <= 1'b1;
      clr_cnt_r <= '0;
      node_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (state_nxt != S_CLEAR) begin
          init_r    <= 1'b0;
          clr_cnt_r <= '0;
        end
      end
      if (state_r == S_SCALE) begin
        node_r <= '0;
      end else if (state_r == S_ADD) begin
        node_r <= node_r + 1'b1;
      end
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r      <= in_command;
      dx_r       <= 33'(in_pos_x) - 33'(origin_x_r);
      dy_r       <= 33'(in_pos_y) - 33'(origin_y_r);
      charge_r   <= in_particle_charge;
      rd_ok_r    <= (32'(in_read_col) < 32'(GRID_X)) && (32'(in_read_row) < 32'(GRID_Y));
      rd_addr_r  <= ADDR_W'(in_read_row) * ADDR_W'(GRID_X) + ADDR_W'(in_read_col);
      res_cell_r <= '0;
      res_oob_r  <= 1'b0;
      res_sat_r  <= 1'b0;
    end
    unique case (state_r)
      S_LOCY: begin
        res_oob_r <= loc_oob;
        ix_r      <= mul_r[32 +: COL_W];
        fx_r      <= mul_r[31:16];
      end
      S_CHARGE: begin
        res_oob_r <= res_oob_r | loc_oob;
        iy_r      <= mul_r[32 +: ROW_W];
        fy_r      <= mul_r[31:16];
      end
      S_SCALE: a_r <= mul_r[63:16];
      S_BLO:   acc_r <= mul_r[48:0];
      S_BSUM:  val_r <= 48'(acc_r + $signed({32'b0, mul_r[32:16]}));
      S_CLO:   acc_r <= mul_r[48:0];
      S_CSUM:  val_r <= 48'(acc_r + $signed({32'b0, mul_r[32:16]}));
      S_ADD:   res_sat_r <= res_sat_r | sum_hi | sum_lo;
      S_RDCAP: res_cell_r <= rd_ok_r ? mem_rdata_r : '0;
      default: ;
    endcase
  end

  // Grid memory: one port, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= grid_mem[mem_addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_cell_r <= res_cell_r;
      out_oob_r  <= res_oob_r;
      out_sat_r  <= res_sat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_value  = out_cell_r;
  assign out_out_of_mesh = out_oob_r;
  assign out_saturated   = out_sat_r;

  // A dropped deposit never reports a clamped sum
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_out_of_mesh && out_saturated))
    else $error("out_of_mesh and saturated both set");

  // Grid writes stay inside the grid
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_addr} < (ADDR_W+1)'(GRID_CELLS)))
    else $error("grid write address out of range");

  // A new result is only launched from the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");

  // Only a deposit command reaches the node update
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> (cmd_r == CMD_DEPOSIT))
    else $error("node update without deposit command");

endmodule
`default_nettype wire
